>>> src/dqi_pkg.sv
// Shared constants, codes and control types of the indexed double-ended queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package dqi_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths of the beats
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    // Input beat width, padded to whole bytes
    localparam int IN_TDATA_W = ((OP_W + VALUE_W + POS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted input beat
        logic exec;      // decide, update pointers, access the ring store
        logic load_out;  // move the result into the output register
    } dqi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } dqi_stat_t;

endpackage
`default_nettype wire

>>> src/double_ended_queue_indexed.sv
// Indexed double-ended queue on a ring store with front pointer and count.
// Sequence: the accepted beat is captured, then executed against the pointers and
// ring store, then its result is loaded into the output register once that is free.
// A new operation is accepted only after the previous result has been loaded.
// Reset: aresetn synchronous, active low; empties the queue, store not cleared.
// Depends on dqi_pkg, dqi_ctrl and dqi_datapath.
`default_nettype none
module double_ended_queue_indexed #(
    parameter int CAPACITY   = dqi_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = dqi_pkg::DEF_DATA_WIDTH,
    localparam int COUNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_TDATA_W =
        ((dqi_pkg::VALUE_W + dqi_pkg::STATUS_W + COUNT_W + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // operation, push_value, position
    input  wire logic [dqi_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_data, status, entry_count
    output logic [OUT_TDATA_W-1:0]                 m_tdata
);
    import dqi_pkg::*;

    localparam int IN_USED  = OP_W + VALUE_W + POS_W;

    dqi_cmd_t  cmd;
    dqi_stat_t stat;

    logic [VALUE_W-1:0]  out_read_data;
    logic [STATUS_W-1:0] out_status;
    logic [COUNT_W-1:0]  out_entry_count;
    logic [IN_USED-1:0]  in_fields;

    assign in_fields = s_tdata[IN_USED-1:0];

    dqi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dqi_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_operation    (in_fields[OP_W-1:0]),
        .in_push_value   (in_fields[OP_W+VALUE_W-1:OP_W]),
        .in_position     (in_fields[IN_USED-1:OP_W+VALUE_W]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_read_data   (out_read_data),
        .out_status      (out_status),
        .out_entry_count (out_entry_count)
    );

    // Pack the result beat, first field lowest
    assign m_tdata = OUT_TDATA_W'({out_entry_count, out_status, out_read_data});

endmodule
`default_nettype wire

>>> src/dqi_ctrl.sv
// Controller state machine of the indexed double-ended queue.
// Depends on dqi_pkg for the command and status types.
`default_nettype none
module dqi_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  dqi_pkg::dqi_stat_t     stat,
    output dqi_pkg::dqi_cmd_t      cmd
);
    import dqi_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode commands and next state
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> src/dqi_datapath.sv
// Datapath of the indexed double-ended queue: input capture, ring pointers,
// ring store and output register. Depends on dqi_pkg.
`default_nettype none
module dqi_datapath #(
    parameter int CAPACITY   = dqi_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = dqi_pkg::DEF_DATA_WIDTH,
    localparam int COUNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  dqi_pkg::dqi_cmd_t                  cmd,
    output dqi_pkg::dqi_stat_t                 stat,
    input  wire logic [dqi_pkg::OP_W-1:0]      in_operation,
    input  wire logic [dqi_pkg::VALUE_W-1:0]   in_push_value,
    input  wire logic [dqi_pkg::POS_W-1:0]     in_position,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [dqi_pkg::VALUE_W-1:0]        out_read_data,
    output logic [dqi_pkg::STATUS_W-1:0]       out_status,
    output logic [COUNT_W-1:0]                 out_entry_count
);
    import dqi_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(CAPACITY - 1);
    localparam logic [ADDR_W:0]    CAP_WIDE  = (ADDR_W + 1)'(CAPACITY);
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    // Captured input beat
    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;

    // Queue state
    logic [ADDR_W-1:0]  front_reg;
    logic [ADDR_W-1:0]  front_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Ring store
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Result held between execute and output load
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_has_data_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_data_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    // Decode helpers
    logic                is_full;
    logic                is_empty;
    logic                pos_ok;
    logic [COUNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0]   front_dec;
    logic [ADDR_W-1:0]   front_inc;
    logic [ADDR_W-1:0]   offset;
    logic [ADDR_W:0]     slot_sum;
    logic [ADDR_W-1:0]   slot;
    logic [ADDR_W-1:0]   wr_addr;
    logic                mem_we;
    logic                mem_re;
    logic                has_data;
    logic [STATUS_W-1:0] status_c;
    logic [63:0]         value_wide;
    logic [63:0]         rd_wide;

    assign is_full   = (count_reg == CAP_COUNT);
    assign is_empty  = (count_reg == '0);
    assign pos_ok    = (CMP_W'(pos_reg) < CMP_W'(count_reg));
    assign count_m1  = count_reg - COUNT_W'(1);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - ADDR_W'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + ADDR_W'(1);

    // Wrap front plus offset into the ring
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= CAP_WIDE) ? ADDR_W'(slot_sum - CAP_WIDE)
                                             : slot_sum[ADDR_W-1:0];

    // Decode the operation against the queue state
    always_comb begin
        offset     = '0;
        wr_addr    = slot;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        has_data   = 1'b0;
        status_c   = ST_OK;
        front_next = front_reg;
        count_next = count_reg;
        unique case (op_reg)
            OP_PUSH_BACK: begin
                offset = ADDR_W'(count_reg);
                if (is_full) begin
                    status_c = ST_FULL;
                end else begin
                    mem_we     = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                wr_addr = front_dec;
                if (is_full) begin
                    status_c = ST_FULL;
                end else begin
                    mem_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                offset = count_m1[ADDR_W-1:0];
                if (is_empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    mem_re     = 1'b1;
                    has_data   = 1'b1;
                    count_next = count_m1;
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    mem_re     = 1'b1;
                    has_data   = 1'b1;
                    front_next = front_inc;
                    count_next = count_m1;
                end
            end
            OP_READ: begin
                offset = ADDR_W'(pos_reg);
                if (!pos_ok) begin
                    status_c = ST_RANGE;
                end else begin
                    mem_re   = 1'b1;
                    has_data = 1'b1;
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= in_operation;
            value_reg <= in_push_value;
            pos_reg   <= in_position;
        end
    end

    // Update pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Hold the decided result until the output load
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg   <= status_c;
            res_has_data_reg <= has_data;
            res_count_reg    <= count_next;
        end
    end

    // Ring store, one write and one registered read port
    assign value_wide = 64'(value_reg);

    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[wr_addr] <= value_wide[DATA_WIDTH-1:0];
        end
        if (cmd.exec && mem_re) begin
            rd_data_reg <= mem[slot];
        end
    end

    // Output register
    assign rd_wide = 64'(rd_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg   <= res_has_data_reg ? rd_wide[VALUE_W-1:0] : '0;
            m_status_reg <= res_status_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign out_read_data   = m_data_reg;
    assign out_status      = m_status_reg;
    assign out_entry_count = m_count_reg;

endmodule
`default_nettype wire

>>> verif/double_ended_queue_indexed_test.sv
// Self-checking testbench for double_ended_queue_indexed: drives operation beats,
// mirrors the queue state to predict every result beat, and compares field by field.
// Depends on dqi_pkg and the double_ended_queue_indexed RTL.
`default_nettype none
module double_ended_queue_indexed_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dqi_pkg::*;

    localparam int DEPTH       = DEF_CAPACITY;
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);
    localparam int RES_TDATA_W = ((VALUE_W + STATUS_W + COUNT_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [VALUE_W-1:0]    data;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_BITS-1:0] count;
    } deque_result_t;

    // Mirror of the queue: ring slots, front pointer and count, plus the
    // results still owed by the block in acceptance order.
    class deque_mirror;
        logic [VALUE_W-1:0]    slots [DEPTH];
        logic [POS_W-1:0]      front;
        logic [COUNT_BITS-1:0] count;
        deque_result_t         owed_results [$];
        int errors;
        int ops_seen;
        int full_hits;
        int empty_hits;
        int range_hits;
        int peak;

        function new();
            front      = '0;
            count      = '0;
            errors     = 0;
            ops_seen   = 0;
            full_hits  = 0;
            empty_hits = 0;
            range_hits = 0;
            peak       = 0;
        endfunction

        // Apply one accepted operation and queue the result it must produce
        function void note_operation(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                     logic [POS_W-1:0] pos);
            deque_result_t r;
            logic [POS_W-1:0] slot;
            r.data   = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH_BACK: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slot = front + POS_W'(count);
                        slots[slot] = value;
                        count++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        front = front - 1'b1;
                        slots[front] = value;
                        count++;
                    end
                end
                OP_POP_BACK: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        slot = front + POS_W'(count - 1'b1);
                        r.data = slots[slot];
                        count--;
                    end
                end
                OP_POP_FRONT: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data = slots[front];
                        front = front + 1'b1;
                        count--;
                    end
                end
                OP_READ: begin
                    if ({1'b0, pos} >= count) begin
                        r.status = ST_RANGE;
                    end else begin
                        slot = front + pos;
                        r.data = slots[slot];
                    end
                end
                default: begin
                    // unused codes leave everything alone
                end
            endcase
            r.count = count;
            owed_results.push_back(r);
            ops_seen++;
            if (r.status == ST_FULL) full_hits++;
            if (r.status == ST_EMPTY) empty_hits++;
            if (r.status == ST_RANGE) range_hits++;
            if (count > peak) peak = count;
        endfunction

        // Compare one result beat against the oldest owed result
        function void check_result(logic [RES_TDATA_W-1:0] beat);
            deque_result_t want;
            logic [VALUE_W-1:0]    got_data;
            logic [STATUS_W-1:0]   got_status;
            logic [COUNT_BITS-1:0] got_count;
            got_data   = beat[VALUE_W-1:0];
            got_status = beat[VALUE_W +: STATUS_W];
            got_count  = beat[VALUE_W + STATUS_W +: COUNT_BITS];
            if (owed_results.size() == 0) begin
                $error("result beat with no operation pending: data %0d status %0d count %0d",
                       $signed(got_data), got_status, got_count);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got_data !== want.data) begin
                $error("read_data mismatch: expected %0d, actual %0d",
                       $signed(want.data), $signed(got_data));
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
                errors++;
            end
            if (got_count !== want.count) begin
                $error("entry_count mismatch: expected %0d, actual %0d", want.count, got_count);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RES_TDATA_W-1:0] m_tdata;

    deque_mirror mirror;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    double_ended_queue_indexed i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Drive m_tready: long hold-off when requested, else random stalls
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Observe both channels, feed the mirror, and watch for a hung block
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mirror.note_operation(s_tdata[OP_W-1:0], s_tdata[OP_W +: VALUE_W],
                                      s_tdata[OP_W + VALUE_W +: POS_W]);
            end
            if (m_tvalid && m_tready) begin
                mirror.check_result(m_tdata);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one operation beat, with random idle cycles ahead of it
    task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({pos, value, op});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Random mix of pushes, pops, reads and unused codes, reads mostly inside the queue
    task automatic run_mixed(input int n);
        int pick;
        int depth;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        repeat (n) begin
            pick  = $urandom_range(99);
            depth = mirror.count;
            if (pick < 20)      op = OP_PUSH_BACK;
            else if (pick < 38) op = OP_PUSH_FRONT;
            else if (pick < 55) op = OP_POP_BACK;
            else if (pick < 70) op = OP_POP_FRONT;
            else if (pick < 95) op = OP_READ;
            else                op = OP_W'($urandom_range(7, 5));
            if (depth > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(depth - 1));
            else pos = POS_W'($urandom);
            send_op(op, $urandom, pos);
        end
    endtask

    // Push to full and past it, read across the whole ring, then drain past empty
    task automatic fill_and_drain();
        repeat (DEPTH + 4) begin
            send_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, POS_W'($urandom));
        end
        set_idling(67, 0);
        send_op(OP_READ, $urandom, 8'd255);
        send_op(OP_READ, $urandom, 8'd0);
        repeat (24) send_op(OP_READ, $urandom, POS_W'($urandom));
        set_idling(37, 37);
        repeat (DEPTH + 3) begin
            send_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom, POS_W'($urandom));
        end
    endtask

    initial begin
        int send_modes [4] = '{0, 67, 0, 37};
        int recv_modes [4] = '{0, 0, 67, 37};
        mirror = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pops and read, unused codes, extreme values, wrap of front
        set_idling(0, 0);
        send_op(OP_POP_BACK, 32'h0, 8'd0);
        send_op(OP_POP_FRONT, 32'hFFFF_FFFF, 8'd255);
        send_op(OP_READ, 32'h0, 8'd0);
        send_op(OP_W'(5), $urandom, POS_W'($urandom));
        send_op(OP_W'(6), $urandom, POS_W'($urandom));
        send_op(OP_W'(7), 32'hFFFF_FFFF, 8'hFF);
        send_op(OP_PUSH_BACK, 32'h7FFF_FFFF, 8'h00);
        send_op(OP_PUSH_FRONT, 32'h8000_0000, 8'hFF);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 8'h00);
        send_op(OP_PUSH_FRONT, 32'h0000_0000, 8'h00);
        send_op(OP_READ, $urandom, 8'd0);
        send_op(OP_READ, $urandom, 8'd3);
        send_op(OP_READ, $urandom, 8'd4);
        send_op(OP_READ, $urandom, 8'd255);
        send_op(OP_POP_BACK, $urandom, 8'd0);
        send_op(OP_POP_FRONT, $urandom, 8'd0);
        send_op(OP_READ, $urandom, 8'd1);
        send_op(OP_POP_FRONT, $urandom, 8'd0);
        send_op(OP_POP_BACK, $urandom, 8'd0);
        send_op(OP_POP_BACK, $urandom, 8'd0);
        send_op(OP_PUSH_FRONT, 32'd1, 8'd0);
        send_op(OP_POP_BACK, $urandom, 8'd0);

        // Full and empty boundaries
        set_idling(0, 67);
        fill_and_drain();

        // Random mix, rotating idling; one segment holds the receiver off
        for (int seg = 0; seg < 8; seg++) begin
            set_idling(send_modes[seg % 4], recv_modes[seg % 4]);
            if (seg == 4) hold_request = HOLD_CYCLES;
            run_mixed(50);
        end

        // Drain what is still owed, then allow for the pipeline latency
        s_tvalid <= 1'b0;
        set_idling(0, 0);
        @(posedge aclk);
        while (mirror.owed_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mirror.owed_results.size() != 0) begin
            $error("result beats missing: expected 0 outstanding, actual %0d",
                   mirror.owed_results.size());
            mirror.errors++;
        end

        $display("Ran %0d operations, peak depth %0d of %0d.",
                 mirror.ops_seen, mirror.peak, DEPTH);
        $display("Refused pushes when full: %0d, pops on empty: %0d, reads out of range: %0d.",
                 mirror.full_hits, mirror.empty_hits, mirror.range_hits);
        if (mirror.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
